/* rtl/sli_pkg.sv */
// Shared types and constants for the sorted list insert/delete unit.
package sli_pkg;

  // Capacity of the list and the widths that follow from it.
  localparam int unsigned DEPTH = 8;
  localparam int unsigned IdxW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW  = $clog2(DEPTH + 1);
  localparam int unsigned ValW  = 32;

  // Operation codes carried by the input beat.
  localparam logic CmdInsert = 1'b0;
  localparam logic CmdDelete = 1'b1;

  // Result status codes.
  typedef enum logic [1:0] {
    StDone     = 2'd0,
    StNotFound = 2'd1,
    StFull     = 2'd2
  } status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic ins_step;
    logic srch_step;
    logic shift_step;
  } dp_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic ins_last;
    logic srch_miss;
    logic srch_hit;
    logic shift_last;
  } dp_stat_t;

endpackage

/* rtl/sorted_list_insert_delete_unit.sv */
// Top level of the sorted list unit: an ascending list kept in order by insert and delete.
// An insert moves each larger entry up one place and then places the value (a full list is
//   refused); a delete searches for the value by halving the range, then moves each later
//   entry down one place. One item at a time; start is taken again the cycle after done_o.
// Reset (rst_ni low, asynchronous) empties the list and returns the controller to idle.
module sorted_list_insert_delete_unit import sli_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  logic                   cmd_i,
  input  logic signed [ValW-1:0] value_i,
  output logic                   done_o,
  output logic [1:0]             status_o,
  output logic [IdxW-1:0]        position_o,
  output logic [CntW-1:0]        fill_count_o
);

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;
  status_e  status;

  sli_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .op_i   (cmd_i),
    .stat_i (dp_stat),
    .cmd_o  (dp_cmd),
    .busy   (busy),
    .done_o (done_o)
  );

  sli_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (dp_cmd),
    .value_i      (value_i),
    .stat_o       (dp_stat),
    .status_o     (status),
    .position_o   (position_o),
    .fill_count_o (fill_count_o)
  );

  assign status_o = status;

endmodule

/* rtl/sli_ctrl.sv */
// Controller state machine that sequences insert, search and shift steps.
module sli_ctrl import sli_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  input  logic     op_i,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o,
  output logic     busy,
  output logic     done_o
);

  localparam logic [2:0] SIdle  = 3'd0;
  localparam logic [2:0] SIns   = 3'd1;
  localparam logic [2:0] SSrch  = 3'd2;
  localparam logic [2:0] SShift = 3'd3;
  localparam logic [2:0] SResp  = 3'd4;

  logic [2:0] state_q, state_d;

  // Next state and datapath commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      SIdle: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = (op_i == CmdInsert) ? SIns : SSrch;
        end
      end
      SIns: begin
        cmd_o.ins_step = 1'b1;
        if (stat_i.ins_last) state_d = SResp;
      end
      SSrch: begin
        cmd_o.srch_step = 1'b1;
        if (stat_i.srch_miss) begin
          state_d = SResp;
        end else if (stat_i.srch_hit) begin
          state_d = SShift;
        end
      end
      SShift: begin
        cmd_o.shift_step = 1'b1;
        if (stat_i.shift_last) state_d = SResp;
      end
      SResp: begin
        state_d = SIdle;
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy   = (state_q != SIdle);
  assign done_o = (state_q == SResp);

endmodule

/* rtl/sli_datapath.sv */
// Datapath holding the list, the fill count and the search and shift registers.
module sli_datapath import sli_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  dp_cmd_t                cmd_i,
  input  logic signed [ValW-1:0] value_i,
  output dp_stat_t               stat_o,
  output status_e                status_o,
  output logic [IdxW-1:0]        position_o,
  output logic [CntW-1:0]        fill_count_o
);

  logic signed [ValW-1:0] entries_q [DEPTH];
  logic signed [ValW-1:0] val_q;
  logic [CntW-1:0]        count_q;
  logic [CntW-1:0]        k_q;
  logic [CntW-1:0]        lo_q;
  logic [CntW-1:0]        hi_q;
  status_e                status_q;
  logic [IdxW-1:0]        pos_q;

  logic                   full;
  logic [CntW:0]          mid_sum;
  logic [IdxW-1:0]        mid;
  logic [CntW-1:0]        k_dec;
  logic [CntW:0]          k_inc;
  logic [IdxW-1:0]        rd_idx;
  logic signed [ValW-1:0] rd_data;
  logic                   ins_stop;
  logic                   wr_en;
  logic signed [ValW-1:0] wr_data;

  // Address arithmetic for the single read port.
  assign full    = (count_q == CntW'(DEPTH));
  assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q} - (CntW + 1)'(1);
  assign mid     = mid_sum[IdxW:1];
  assign k_dec   = k_q - CntW'(1);
  assign k_inc   = {1'b0, k_q} + (CntW + 1)'(1);

  always_comb begin
    if (cmd_i.ins_step) begin
      rd_idx = k_dec[IdxW-1:0];
    end else if (cmd_i.srch_step) begin
      rd_idx = mid;
    end else begin
      rd_idx = k_inc[IdxW-1:0];
    end
  end

  assign rd_data = entries_q[rd_idx];

  // Step conditions reported to the controller.
  assign ins_stop          = (k_q == '0) || !(val_q < rd_data);
  assign stat_o.ins_last   = full || ins_stop;
  assign stat_o.srch_miss  = !(lo_q < hi_q);
  assign stat_o.srch_hit   = (lo_q < hi_q) && (val_q == rd_data);
  assign stat_o.shift_last = (k_inc >= {1'b0, count_q});

  // List write port: an insert step either places the value or moves an entry up,
  // a shift step moves an entry down.
  assign wr_en   = (cmd_i.ins_step && !full) || (cmd_i.shift_step && !stat_o.shift_last);
  assign wr_data = (cmd_i.ins_step && ins_stop) ? val_q : rd_data;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      entries_q[k_q[IdxW-1:0]] <= wr_data;
    end
  end

  // Fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.ins_step && !full && ins_stop) begin
      count_q <= count_q + CntW'(1);
    end else if (cmd_i.shift_step && stat_o.shift_last) begin
      count_q <= count_q - CntW'(1);
    end
  end

  // Working registers and result fields.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      val_q <= value_i;
      k_q   <= count_q;
      lo_q  <= '0;
      hi_q  <= count_q;
    end else if (cmd_i.ins_step) begin
      if (full) begin
        status_q <= StFull;
        pos_q    <= '0;
      end else if (ins_stop) begin
        status_q <= StDone;
        pos_q    <= k_q[IdxW-1:0];
      end else begin
        k_q <= k_dec;
      end
    end else if (cmd_i.srch_step) begin
      if (stat_o.srch_miss) begin
        status_q <= StNotFound;
        pos_q    <= '0;
      end else if (stat_o.srch_hit) begin
        k_q   <= CntW'(mid);
        pos_q <= mid;
      end else if (val_q < rd_data) begin
        hi_q <= CntW'(mid);
      end else begin
        lo_q <= CntW'(mid) + CntW'(1);
      end
    end else if (cmd_i.shift_step) begin
      if (stat_o.shift_last) begin
        status_q <= StDone;
      end else begin
        k_q <= k_inc[CntW-1:0];
      end
    end
  end

  assign status_o     = status_q;
  assign position_o   = pos_q;
  assign fill_count_o = count_q;

endmodule

/* rtl/sli_checker.sv */
// Port-level checker for the sorted list unit, bound to the top level.
module sli_checker import sli_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   start,
  input logic                   busy,
  input logic                   done_o,
  input logic [1:0]             status_o,
  input logic [IdxW-1:0]        position_o,
  input logic [CntW-1:0]        fill_count_o
);

  // A result beat only appears while an item is in flight.
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> busy)
    else $error("done_o without an item in flight");

  // The unit is free again right after the result beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |=> !busy)
    else $error("busy stays high after the result beat");

  // An accepted item keeps the unit busy in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni) (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  // A refused insert reports a full list.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (done_o && status_o == StFull) |-> (fill_count_o == CntW'(DEPTH) && position_o == '0))
    else $error("full status with a list that is not full");

  // Status is a known code and the fill count stays within capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      done_o |-> (status_o != 2'd3 && fill_count_o <= CntW'(DEPTH)))
    else $error("bad status code or fill count");

endmodule

bind sorted_list_insert_delete_unit sli_checker u_sli_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .done_o       (done_o),
  .status_o     (status_o),
  .position_o   (position_o),
  .fill_count_o (fill_count_o)
);

/* bench/tb_sorted_list_insert_delete_unit.sv */
// Testbench for the sorted list unit: directed and random beats checked against a list model.
module tb_sorted_list_insert_delete_unit import sli_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  // Extreme signed values used by the directed tests.
  localparam logic signed [ValW-1:0] ValMax = 32'sh7FFF_FFFF;
  localparam logic signed [ValW-1:0] ValMin = 32'sh8000_0000;

  // One result beat as the list model predicts it.
  typedef struct {
    status_e         status;
    logic [IdxW-1:0] position;
    logic [CntW-1:0] fill;
  } list_result_t;

  logic                   clk_i   = 1'b0;
  logic                   rst_ni  = 1'b0;
  logic                   start   = 1'b0;
  logic                   cmd_i   = CmdInsert;
  logic signed [ValW-1:0] value_i = '0;
  logic                   busy;
  logic                   done_o;
  logic [1:0]             status_o;
  logic [IdxW-1:0]        position_o;
  logic [CntW-1:0]        fill_count_o;

  // Model of the list contents and the results still owed by the block.
  logic signed [ValW-1:0] model_list [DEPTH];
  int unsigned            model_fill = 0;
  list_result_t           pending_results [$];
  int unsigned            mismatch_count = 0;

  sorted_list_insert_delete_unit u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .cmd_i        (cmd_i),
    .value_i      (value_i),
    .done_o       (done_o),
    .status_o     (status_o),
    .position_o   (position_o),
    .fill_count_o (fill_count_o)
  );

  // Clock with a 4 ns period.
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Safety net in case the block stops answering.
  initial begin
    #(2_000_000);
    $display("*** FAILED ***");
    $finish;
  end

  // Apply one operation to the model list and return the result it must produce.
  function automatic list_result_t update_sorted_list(logic op, logic signed [ValW-1:0] v);
    list_result_t r;
    int           k;
    int           lo;
    int           hi;
    int           mid;
    bit           hit;
    r.status   = StDone;
    r.position = '0;
    if (op == CmdInsert) begin
      if (model_fill >= DEPTH) begin
        r.status = StFull;
      end else begin
        // Larger entries move up; the new value lands after any equal ones.
        k = model_fill;
        while (k > 0 && v < model_list[k-1]) begin
          model_list[k] = model_list[k-1];
          k--;
        end
        model_list[k] = v;
        model_fill++;
        r.position = k[IdxW-1:0];
      end
    end else begin
      // Binary search with the midpoint rounded down.
      lo  = 0;
      hi  = int'(model_fill) - 1;
      hit = 1'b0;
      mid = 0;
      while (!hit && hi >= lo) begin
        mid = (lo + hi) / 2;
        if (v < model_list[mid]) hi = mid - 1;
        else if (v > model_list[mid]) lo = mid + 1;
        else hit = 1'b1;
      end
      if (hit) begin
        for (k = mid; k + 1 < int'(model_fill); k++) model_list[k] = model_list[k+1];
        model_fill--;
        r.position = mid[IdxW-1:0];
      end else begin
        r.status = StNotFound;
      end
    end
    r.fill = model_fill[CntW-1:0];
    return r;
  endfunction

  // Compare each result beat with the oldest prediction.
  always @(posedge clk_i) begin : check_results
    list_result_t want;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: unexpected result status=%0d position=%0d fill=%0d",
                   $realtime, status_o, position_o, fill_count_o);
      end else begin
        want = pending_results.pop_front();
        if (status_o !== want.status || position_o !== want.position ||
            fill_count_o !== want.fill) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: mismatch expected status=%0d position=%0d fill=%0d, got %0d %0d %0d",
                     $realtime, want.status, want.position, want.fill,
                     status_o, position_o, fill_count_o);
        end
      end
    end
  end

  // Drive one beat and hold it until the block takes it.
  task automatic send_item(input logic op, input logic signed [ValW-1:0] v);
    start   <= 1'b1;
    cmd_i   <= op;
    value_i <= v;
    do @(posedge clk_i); while (busy);
    pending_results.push_back(update_sorted_list(op, v));
  endtask

  task automatic idle_burst();
    start <= 1'b0;
    repeat ($urandom_range(5, 1)) @(posedge clk_i);
  endtask

  // Hold off new beats until every predicted result has arrived.
  task automatic wait_for_results();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Values spread over the full range, near zero, at the extremes and next to stored entries.
  function automatic logic signed [ValW-1:0] pick_value();
    logic signed [ValW-1:0] v;
    case ($urandom_range(3, 0))
      0: v = $urandom;
      1: v = int'($urandom_range(8, 0)) - 4;
      2: begin
        case ($urandom_range(5, 0))
          0: v = ValMax;
          1: v = ValMin;
          2: v = ValMax - 1;
          3: v = ValMin + 1;
          4: v = -1;
          default: v = 0;
        endcase
      end
      default: begin
        if (model_fill > 0)
          v = model_list[$urandom_range(model_fill - 1, 0)] + int'($urandom_range(2, 0)) - 1;
        else
          v = $urandom;
      end
    endcase
    return v;
  endfunction

  // One random operation; deletes mostly target values that are in the list.
  task automatic random_item(input int unsigned insert_pct);
    logic                   op;
    logic signed [ValW-1:0] v;
    op = ($urandom_range(99, 0) < insert_pct) ? CmdInsert : CmdDelete;
    if (op == CmdDelete && model_fill > 0 && $urandom_range(3, 0) != 0)
      v = model_list[$urandom_range(model_fill - 1, 0)];
    else
      v = pick_value();
    send_item(op, v);
  endtask

  function automatic int unsigned pick_insert_mix();
    case ($urandom_range(4, 0))
      0: return 10;
      1: return 30;
      2: return 50;
      3: return 70;
      default: return 90;
    endcase
  endfunction

  // Deletes on an empty list find nothing.
  task automatic test_empty_list();
    send_item(CmdDelete, 0);
    send_item(CmdDelete, ValMin);
  endtask

  // Fill the list with extremes and duplicates, then insert into a full list.
  task automatic test_fill_to_capacity();
    send_item(CmdInsert, ValMax);
    send_item(CmdInsert, ValMin);
    send_item(CmdInsert, 0);
    send_item(CmdInsert, -1);
    send_item(CmdInsert, 5);
    send_item(CmdInsert, 5);
    idle_burst();
    send_item(CmdInsert, 5);
    send_item(CmdInsert, 1);
    send_item(CmdInsert, 7);
    send_item(CmdInsert, ValMin);
  endtask

  // Delete duplicates, absent values and extremes until the list is empty again.
  task automatic test_delete_lookup();
    send_item(CmdDelete, 5);
    send_item(CmdDelete, 2);
    send_item(CmdDelete, ValMax);
    send_item(CmdDelete, ValMin);
    send_item(CmdDelete, 5);
    idle_burst();
    send_item(CmdDelete, 5);
    send_item(CmdDelete, 1);
    send_item(CmdDelete, 0);
    send_item(CmdDelete, -1);
    send_item(CmdDelete, -1);
  endtask

  // Random traffic with idle bursts and occasional full pauses; the mix drifts so
  // that the fill level sweeps from empty to full.
  task automatic test_random_traffic(input int unsigned n);
    int unsigned insert_pct;
    wait_for_results();
    insert_pct = 50;
    for (int unsigned i = 0; i < n; i++) begin
      if (i % 40 == 0) insert_pct = pick_insert_mix();
      if ($urandom_range(3, 0) == 0) idle_burst();
      else if ($urandom_range(199, 0) == 0) wait_for_results();
      random_item(insert_pct);
    end
  endtask

  // Back-to-back beats with no idling at all.
  task automatic test_back_to_back(input int unsigned n);
    int unsigned insert_pct;
    insert_pct = 50;
    for (int unsigned i = 0; i < n; i++) begin
      if (i % 30 == 0) insert_pct = pick_insert_mix();
      random_item(insert_pct);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_list();
    test_fill_to_capacity();
    test_delete_lookup();
    test_random_traffic(1700);
    test_back_to_back(180);
    wait_for_results();
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/sli_pkg.sv
rtl/sli_ctrl.sv
rtl/sli_datapath.sv
rtl/sorted_list_insert_delete_unit.sv
rtl/sli_checker.sv
bench/tb_sorted_list_insert_delete_unit.sv
